// ===== rtl/swma_pkg.sv =====
// Package for the stack with middle access: payload structs, operation and
// status codes, FSM state type and the memory control strobes.
// No dependencies.
`default_nettype none

package swma_pkg;

    // Fixed widths of the payload fields.
    localparam int DATA_W = 32;
    localparam int OCC_W  = 9;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        OP_PUSH          = 2'd0,
        OP_POP           = 2'd1,
        OP_MIDDLE        = 2'd2,
        OP_DELETE_MIDDLE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_RSVD  = 2'd3
    } t_status;

    // One input beat.
    typedef struct packed {
        t_op                      operation;
        logic signed [DATA_W-1:0] push_value;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_result;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT
    } t_state;

    // Memory port strobes from the sequencer.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== rtl/swma_mem.sv =====
// Entry store of the stack: one write port and one read port, with the
// read data registered. Depends on swma_pkg.
`default_nettype none

module swma_mem
    import swma_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire t_mem_ctl          i_ctl,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swma_ctrl.sv =====
// Sequencer of the stack: entry count, operation decode, memory accesses,
// the shift loop of delete middle and the result register. Depends on swma_pkg.
`default_nettype none

module swma_ctrl
    import swma_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire t_cmd              i_cmd,
    output logic                   busy,
    output logic                   o_result_valid,
    output t_result                o_result,
    output t_mem_ctl               o_mem_ctl,
    output logic      [AW-1:0]     o_waddr,
    output logic      [DATA_W-1:0] o_wdata,
    output logic      [AW-1:0]     o_raddr,
    input  wire logic [DATA_W-1:0] i_rdata
);

    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx,   n_idx;
    logic [AW-1:0] r_last,  n_last;
    t_result       r_res,   n_res;
    logic          r_valid, n_valid;

    logic          accept;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] mid;
    logic [AW-1:0] idx_p1;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign count_m1 = r_count - COUNT_ONE;
    assign mid      = count_m1 >> 1;
    assign idx_p1   = r_idx + AW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && r_count != '0) begin
                    case (i_cmd.operation)
                        OP_POP, OP_MIDDLE: n_state = S_READ;
                        OP_DELETE_MIDDLE: begin
                            if (r_count != COUNT_ONE) begin
                                n_state = S_SHIFT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:  n_state = S_IDLE;
            S_SHIFT: begin
                if (idx_p1 == r_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory accesses, count and result.
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_last       = r_last;
        n_res        = r_res;
        n_valid      = 1'b0;
        o_mem_ctl    = '0;
        o_waddr      = r_idx;
        o_wdata      = i_rdata;
        o_raddr      = count_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.result_value = '0;
                    n_res.status       = STS_OK;
                    n_res.occupancy    = OCC_W'(r_count);
                    if (i_cmd.operation == OP_PUSH) begin
                        // Push completes here; a full stack drops the word.
                        n_valid = 1'b1;
                        if (r_count == COUNT_FULL) begin
                            n_res.status = STS_FULL;
                        end else begin
                            o_mem_ctl.we    = 1'b1;
                            o_waddr         = r_count[AW-1:0];
                            o_wdata         = i_cmd.push_value;
                            n_count         = r_count + COUNT_ONE;
                            n_res.occupancy = OCC_W'(n_count);
                        end
                    end else if (r_count == '0) begin
                        n_valid      = 1'b1;
                        n_res.status = STS_EMPTY;
                    end else begin
                        case (i_cmd.operation)
                            OP_POP: begin
                                o_mem_ctl.re = 1'b1;
                                o_raddr      = count_m1[AW-1:0];
                                n_count      = count_m1;
                            end
                            OP_MIDDLE: begin
                                o_mem_ctl.re = 1'b1;
                                o_raddr      = mid[AW-1:0];
                            end
                            default: begin
                                // Delete middle: a single entry needs no shift.
                                if (r_count == COUNT_ONE) begin
                                    n_valid         = 1'b1;
                                    n_count         = '0;
                                    n_res.occupancy = '0;
                                end else begin
                                    o_mem_ctl.re = 1'b1;
                                    o_raddr      = mid[AW-1:0] + AW'(1);
                                    n_idx        = mid[AW-1:0];
                                    n_last       = count_m1[AW-1:0];
                                end
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                // Read data of pop or middle read has arrived.
                n_valid            = 1'b1;
                n_res.result_value = i_rdata;
                n_res.status       = STS_OK;
                n_res.occupancy    = OCC_W'(r_count);
            end
            S_SHIFT: begin
                // Move the word read last cycle down one place, fetch the next.
                o_mem_ctl.we = 1'b1;
                o_waddr      = r_idx;
                o_wdata      = i_rdata;
                if (idx_p1 == r_last) begin
                    n_count            = count_m1;
                    n_valid            = 1'b1;
                    n_res.result_value = '0;
                    n_res.status       = STS_OK;
                    n_res.occupancy    = OCC_W'(count_m1);
                end else begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = idx_p1 + AW'(1);
                    n_idx        = idx_p1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload and loop registers.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_last <= n_last;
        r_res  <= n_res;
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_res;

endmodule

`default_nettype wire

// ===== rtl/stack_with_middle_access.sv =====
// Top level of the stack with middle access: sequencer and entry store.
// Depends on swma_pkg, swma_ctrl and swma_mem.
//
//   Channel   Ports                        Beat taken when
//   command   start, busy, i_cmd           start high and busy low
//   result    o_result_valid, o_result     o_result_valid high (one cycle)
//
// Push, and any operation that ends in an error, completes without busy: the result
// shows in the next cycle and a new command may be given at once.
// Pop and middle read pass through the read state to wait for the registered
// read data of the store. Delete middle moves each entry above the middle down
// one place in turn in the shift state, through the read and write ports.
// Reset clears the count and the sequencer; the store needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module stack_with_middle_access
    import swma_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_cmd    i_cmd,
    output logic         busy,
    output logic         o_result_valid,
    output t_result      o_result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;

    // Sequencer.
    swma_ctrl #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .o_mem_ctl      (mem_ctl),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    // Entry store.
    swma_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/swma_checker.sv =====
// Port-level checks for the stack with middle access, bound to the top level.
// Depends on swma_pkg.
`default_nettype none

module swma_checker
    import swma_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_cmd    i_cmd,
    input wire logic    o_result_valid,
    input wire t_result o_result
);

    // A push beat is answered in the very next cycle.
    a_push_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.operation == OP_PUSH |=> o_result_valid)
        else $error("push beat not answered in the next cycle");

    // A result only follows an accepted beat or a busy cycle.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy) || $past(busy))
        else $error("result without a command beat");

    // An empty status carries a zero word and an empty stack.
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == STS_EMPTY |->
            o_result.occupancy == '0 && o_result.result_value == '0)
        else $error("empty status with non-zero word or occupancy");

    // A full status reports the stack at its capacity.
    a_full_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == STS_FULL |->
            o_result.occupancy == OCC_W'(DEPTH) && o_result.result_value == '0)
        else $error("full status at the wrong occupancy");

    // The reserved status code never appears.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result.status != STS_RSVD)
        else $error("reserved status code on a result");

endmodule

bind stack_with_middle_access swma_checker #(.DEPTH(STACK_DEPTH)) u_swma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
